// File: src/tts_pkg.sv
package tts_pkg;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       text_end;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       run_last;
    logic       output_end;
    logic [2:0] detected_form;
  } out_item_t;

  localparam int TOK_BYTES = 12;
  localparam int QDEPTH    = 4;
  localparam int QAW       = $clog2(QDEPTH);

  // one queue entry: all bytes that one feed step produces
  typedef struct packed {
    logic [TOK_BYTES-1:0][7:0] bytes;
    logic [3:0]                nbytes;
    logic                      item_last;
    logic                      text_end;
    logic [2:0]                form;
  } tok_t;

  typedef struct packed {
    logic [3:0][7:0] b;
    logic [2:0]      n;
  } cp_bytes_t;

  localparam logic [1:0] PH_DET = 2'd0;
  localparam logic [1:0] PH_U8  = 2'd1;
  localparam logic [1:0] PH_U16 = 2'd2;

  localparam logic [2:0] FORM_U8     = 3'd0;
  localparam logic [2:0] FORM_U8MARK = 3'd1;
  localparam logic [2:0] FORM_U16LE  = 3'd2;
  localparam logic [2:0] FORM_U16BE  = 3'd3;
  localparam logic [2:0] FORM_LE32   = 3'd4;
  localparam logic [2:0] FORM_BE32   = 3'd5;

  localparam logic [7:0] MK_LE32 [4] = '{8'hFF, 8'hFE, 8'h00, 8'h00};
  localparam logic [7:0] MK_BE32 [4] = '{8'h00, 8'h00, 8'hFE, 8'hFF};
  localparam logic [7:0] MK_U8   [3] = '{8'hEF, 8'hBB, 8'hBF};
  localparam logic [7:0] FFFD_B  [3] = '{8'hEF, 8'hBF, 8'hBD};

  function automatic logic [2:0] lead_len(input logic [7:0] c);
    logic [2:0] r;
    r = 3'd0;
    if (c inside {[8'hC2:8'hDF]}) r = 3'd2;
    else if (c[7:4] == 4'hE) r = 3'd3;
    else if (c inside {[8'hF0:8'hF4]}) r = 3'd4;
    return r;
  endfunction

  function automatic cp_bytes_t enc_cp(input logic [20:0] cp);
    cp_bytes_t r;
    r.b = '0;
    r.n = 3'd0;
    if (cp < 21'h80) begin
      r.b[0] = cp[7:0];
      r.n = 3'd1;
    end else if (cp < 21'h800) begin
      r.b[0] = {3'b110, cp[10:6]};
      r.b[1] = {2'b10, cp[5:0]};
      r.n = 3'd2;
    end else if (cp < 21'h10000) begin
      r.b[0] = {4'b1110, cp[15:12]};
      r.b[1] = {2'b10, cp[11:6]};
      r.b[2] = {2'b10, cp[5:0]};
      r.n = 3'd3;
    end else begin
      r.b[0] = {5'b11110, cp[20:18]};
      r.b[1] = {2'b10, cp[17:12]};
      r.b[2] = {2'b10, cp[11:6]};
      r.b[3] = {2'b10, cp[5:0]};
      r.n = 3'd4;
    end
    return r;
  endfunction

endpackage

// File: src/text_to_utf8_sanitizer_core.sv
// text to utf-8 sanitizer
// src channel: one raw text byte per request (src_data.in_byte), with
// src_data.text_end set on the final byte of a text. dst channel: one
// utf-8 byte per result, with run_last on the last result of a request,
// output_end on the final result of the text and the detected encoding.
// a text whose requests give no byte ends in one result with byte_valid 0.
// the front takes one request per cycle while the queue has room and no
// mark bytes are re-fed, and turns it into one queue entry of up to 12
// bytes; the back sends one byte per cycle while dst is ready, plus a
// closing step for a request giving two or more bytes, so the sustained
// rate is one request per cycle until expansion fills the 4-entry queue.
// after the byte-order mark is decided, up to 4 bytes (held mark bytes and
// the deciding byte) are re-fed one per cycle while the queue has room,
// blocking src meanwhile. a first result passes the queue entry and the
// output register, and also the hold register for a multi-byte request.
// synchronous reset clears the control state; a text also returns the
// front's decode state to reset values after its final byte. a stalled
// dst fills the output register, hold register, queue, then src_ready drops.
module text_to_utf8_sanitizer_core import tts_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      src_valid,
  output logic      src_ready,
  input  in_item_t  src_data,
  output logic      dst_valid,
  input  logic      dst_ready,
  output out_item_t dst_data
);

  logic push_valid, not_full, pop, not_empty;
  tok_t push_token, head;

  tts_front u_front (
    .clk        (clk),
    .rst        (rst),
    .src_valid  (src_valid),
    .src_ready  (src_ready),
    .src_data   (src_data),
    .push_ready (not_full),
    .push_valid (push_valid),
    .push_token (push_token)
  );

  tts_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push_valid),
    .push_data (push_token),
    .not_full  (not_full),
    .pop       (pop),
    .head      (head),
    .not_empty (not_empty)
  );

  tts_back u_back (
    .clk       (clk),
    .rst       (rst),
    .tok       (head),
    .have      (not_empty),
    .pop       (pop),
    .dst_valid (dst_valid),
    .dst_ready (dst_ready),
    .dst_data  (dst_data)
  );

endmodule

// File: src/tts_front.sv
module tts_front import tts_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     src_valid,
  output logic     src_ready,
  input  in_item_t src_data,
  input  logic     push_ready,
  output logic     push_valid,
  output tok_t     push_token
);

  logic [1:0] phase, phase_next;
  logic [2:0] form, form_next;
  logic [7:0] mark [3];
  logic [7:0] mark_next [3];
  logic [1:0] mark_count, mark_count_next;
  logic [7:0] held [3];
  logic [7:0] held_next [3];
  logic [1:0] hcnt, hcnt_next;
  logic [2:0] explen, explen_next;
  logic [7:0] odd, odd_next;
  logic       oddv, oddv_next;
  logic [9:0] hs, hs_next;
  logic       hsv, hsv_next;
  logic             rp_active, rp_active_next;
  logic [3:0][7:0]  rp_s, rp_s_next;
  logic [2:0]       rp_idx, rp_idx_next;
  logic [2:0]       rp_lim, rp_lim_next;
  logic             rp_end, rp_end_next;

  logic            take;
  logic            f_go, f_last, f_end;
  logic [7:0]      f_byte;
  logic [3:0][7:0] ds;
  logic [2:0]      dk;
  logic            pre_le, pre_be, pre_u8;
  logic            choose_go, bare;
  logic [2:0]      rp_from;
  logic [15:0]     u;
  cp_bytes_t       enc;
  logic [3:0][7:0] mid;
  logic [2:0]      nm;
  logic [2:0]      pre;
  logic [1:0]      post;
  logic            do_lead;
  logic [2:0]      len;
  logic [3:0]      cnt;
  logic [TOK_BYTES-1:0][7:0] tb;
  logic [2:0]      tok_form;

  assign src_ready = !rp_active && push_ready;
  assign take      = src_valid && src_ready;

  always_comb begin
    phase_next      = phase;
    form_next       = form;
    mark_next       = mark;
    mark_count_next = mark_count;
    held_next       = held;
    hcnt_next       = hcnt;
    explen_next     = explen;
    odd_next        = odd;
    oddv_next       = oddv;
    hs_next         = hs;
    hsv_next        = hsv;
    rp_active_next  = rp_active;
    rp_s_next       = rp_s;
    rp_idx_next     = rp_idx;
    rp_lim_next     = rp_lim;
    rp_end_next     = rp_end;
    f_go = 1'b0; f_last = 1'b0; f_end = 1'b0; f_byte = 8'h00;
    choose_go = 1'b0; bare = 1'b0; rp_from = 3'd0;
    tok_form = form;
    u = 16'h0000; enc = '0; mid = '0; nm = 3'd0; pre = 3'd0; post = 2'd0;
    do_lead = 1'b0; len = 3'd0; cnt = 4'd0; tb = '0;

    // mark detection view: stored mark bytes followed by the new byte
    ds[3] = src_data.in_byte;
    for (int j = 0; j < 3; j++) begin
      ds[j] = (2'(j) < mark_count) ? mark[j] : src_data.in_byte;
    end
    dk = {1'b0, mark_count} + 3'd1;
    pre_le = 1'b1; pre_be = 1'b1; pre_u8 = (dk <= 3'd3);
    for (int j = 0; j < 4; j++) begin
      if (3'(j) < dk && ds[j] != MK_LE32[j]) pre_le = 1'b0;
      if (3'(j) < dk && ds[j] != MK_BE32[j]) pre_be = 1'b0;
    end
    for (int j = 0; j < 3; j++) begin
      if (3'(j) < dk && ds[j] != MK_U8[j]) pre_u8 = 1'b0;
    end

    if (rp_active) begin
      if (push_ready) begin
        f_go   = 1'b1;
        f_byte = rp_s[rp_idx[1:0]];
        f_last = (rp_idx + 3'd1 == rp_lim);
        f_end  = f_last && rp_end;
        rp_idx_next = rp_idx + 3'd1;
        if (f_last) rp_active_next = 1'b0;
      end
    end else if (take && phase != PH_DET) begin
      f_go   = 1'b1;
      f_byte = src_data.in_byte;
      f_last = 1'b1;
      f_end  = src_data.text_end;
    end else if (take) begin
      if (dk == 3'd4 && pre_le) begin
        form_next = FORM_LE32; phase_next = PH_U16; rp_from = dk; choose_go = 1'b1;
      end else if (dk == 3'd4 && pre_be) begin
        form_next = FORM_BE32; phase_next = PH_U16; rp_from = dk; choose_go = 1'b1;
      end else if (dk < 3'd4 && (pre_le || pre_be)) begin
        mark_next[mark_count] = src_data.in_byte;
        mark_count_next = dk[1:0];
      end else if (dk >= 3'd2 && ds[0] == 8'hFF && ds[1] == 8'hFE) begin
        form_next = FORM_U16LE; phase_next = PH_U16; rp_from = 3'd2; choose_go = 1'b1;
      end else if (dk == 3'd2 && ds[0] == 8'hFE && ds[1] == 8'hFF) begin
        form_next = FORM_U16BE; phase_next = PH_U16; rp_from = 3'd2; choose_go = 1'b1;
      end else if (dk == 3'd1 && ds[0] == 8'hFE) begin
        mark_next[mark_count] = src_data.in_byte;
        mark_count_next = dk[1:0];
      end else if (dk == 3'd3 && pre_u8) begin
        form_next = FORM_U8MARK; phase_next = PH_U8; rp_from = dk; choose_go = 1'b1;
      end else if (dk < 3'd3 && pre_u8) begin
        mark_next[mark_count] = src_data.in_byte;
        mark_count_next = dk[1:0];
      end else begin
        form_next = FORM_U8; phase_next = PH_U8; rp_from = 3'd0; choose_go = 1'b1;
      end
      // text ends while the mark is still open
      if (!choose_go && src_data.text_end) begin
        choose_go = 1'b1;
        if (dk >= 3'd2 && ds[0] == 8'hFF && ds[1] == 8'hFE) begin
          form_next = FORM_U16LE; phase_next = PH_U16; rp_from = 3'd2;
        end else begin
          form_next = FORM_U8; phase_next = PH_U8; rp_from = 3'd0;
        end
      end
      if (choose_go) begin
        mark_count_next = 2'd0;
        if (rp_from < dk) begin
          rp_active_next = 1'b1;
          rp_s_next      = ds;
          rp_idx_next    = rp_from;
          rp_lim_next    = dk;
          rp_end_next    = src_data.text_end;
        end else if (src_data.text_end) begin
          bare     = 1'b1;
          tok_form = form_next;
        end
      end
    end

    if (f_go) begin
      if (phase == PH_U16) begin
        if (!oddv) begin
          odd_next  = f_byte;
          oddv_next = 1'b1;
        end else begin
          u = (form == FORM_U16BE || form == FORM_BE32) ? {odd, f_byte} : {f_byte, odd};
          oddv_next = 1'b0;
          if (hsv && (u inside {[16'hDC00:16'hDFFF]})) begin
            hsv_next = 1'b0;
            enc = enc_cp(21'h10000 + {1'b0, hs, u[9:0]});
          end else begin
            if (hsv) pre = 3'd1;
            hsv_next = 1'b0;
            if (u inside {[16'hD800:16'hDBFF]}) begin
              hs_next  = u[9:0];
              hsv_next = 1'b1;
            end else if (u inside {[16'hDC00:16'hDFFF]}) begin
              pre = pre + 3'd1;
            end else begin
              enc = enc_cp({5'd0, u});
            end
          end
          mid = enc.b;
          nm  = enc.n;
        end
      end else begin
        if (hcnt == 2'd0) begin
          do_lead = 1'b1;
        end else if (f_byte[7:6] != 2'b10) begin
          pre = {1'b0, hcnt};
          hcnt_next = 2'd0;
          explen_next = 3'd0;
          do_lead = 1'b1;
        end else if ({1'b0, hcnt} + 3'd1 >= explen) begin
          for (int j = 0; j < 3; j++) begin
            if (2'(j) < hcnt) mid[j] = held[j];
          end
          mid[hcnt] = f_byte;
          nm = {1'b0, hcnt} + 3'd1;
          hcnt_next = 2'd0;
          explen_next = 3'd0;
        end else if (hcnt < 2'd3) begin
          held_next[hcnt] = f_byte;
          hcnt_next = hcnt + 2'd1;
        end
        if (do_lead) begin
          len = lead_len(f_byte);
          if (!f_byte[7]) begin
            mid[0] = f_byte;
            nm = 3'd1;
          end else if (len == 3'd0) begin
            pre = pre + 3'd1;
          end else begin
            held_next[0] = f_byte;
            hcnt_next = 2'd1;
            explen_next = len;
          end
        end
      end
    end

    // end of text: a replacement character for each held utf-8 byte or an open high surrogate
    if (f_end) begin
      post = (phase_next == PH_U16) ? {1'b0, hsv_next} : hcnt_next;
    end
    if (f_end || bare) begin
      phase_next = PH_DET; form_next = FORM_U8; mark_count_next = 2'd0;
      hcnt_next = 2'd0; explen_next = 3'd0; odd_next = 8'h00; oddv_next = 1'b0;
      hs_next = 10'd0; hsv_next = 1'b0;
    end

    for (int r = 0; r < 4; r++) begin
      if (3'(r) < pre) begin
        for (int t = 0; t < 3; t++) begin
          tb[cnt] = FFFD_B[t];
          cnt = cnt + 4'd1;
        end
      end
    end
    for (int r = 0; r < 4; r++) begin
      if (3'(r) < nm) begin
        tb[cnt] = mid[r];
        cnt = cnt + 4'd1;
      end
    end
    for (int r = 0; r < 3; r++) begin
      if (2'(r) < post) begin
        for (int t = 0; t < 3; t++) begin
          tb[cnt] = FFFD_B[t];
          cnt = cnt + 4'd1;
        end
      end
    end
  end

  assign push_valid = bare ||
                      (f_go && (cnt != 4'd0 || (f_last && (f_end || rp_active))));
  assign push_token = '{bytes: tb, nbytes: cnt, item_last: f_last || bare,
                        text_end: f_end || bare, form: tok_form};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_DET;
      form       <= FORM_U8;
      mark_count <= 2'd0;
      hcnt       <= 2'd0;
      explen     <= 3'd0;
      oddv       <= 1'b0;
      hsv        <= 1'b0;
      rp_active  <= 1'b0;
    end else begin
      phase      <= phase_next;
      form       <= form_next;
      mark_count <= mark_count_next;
      hcnt       <= hcnt_next;
      explen     <= explen_next;
      oddv       <= oddv_next;
      hsv        <= hsv_next;
      rp_active  <= rp_active_next;
    end
  end

  always_ff @(posedge clk) begin
    mark   <= mark_next;
    held   <= held_next;
    odd    <= odd_next;
    hs     <= hs_next;
    rp_s   <= rp_s_next;
    rp_idx <= rp_idx_next;
    rp_lim <= rp_lim_next;
    rp_end <= rp_end_next;
  end

endmodule

// File: src/tts_fifo.sv
module tts_fifo import tts_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  tok_t push_data,
  output logic not_full,
  input  logic pop,
  output tok_t head,
  output logic not_empty
);

  tok_t           mem [QDEPTH];
  logic [QAW-1:0] wr_ptr, rd_ptr;
  logic [QAW:0]   count;

  assign not_full  = (count != (QAW+1)'(QDEPTH));
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

endmodule

// File: src/tts_back.sv
module tts_back import tts_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  tok_t      tok,
  input  logic      have,
  output logic      pop,
  output logic      dst_valid,
  input  logic      dst_ready,
  output out_item_t dst_data
);

  logic [3:0] idx, idx_next;
  logic       hold_valid, hold_valid_next;
  logic [7:0] hold_byte, hold_byte_next;
  logic [2:0] hold_form, hold_form_next;
  logic       out_free, load_out, at_byte, final_b;
  logic [7:0] b;
  out_item_t  o;

  assign out_free = !dst_valid || dst_ready;
  assign at_byte  = idx < tok.nbytes;
  assign final_b  = tok.item_last && (idx + 4'd1 == tok.nbytes);
  assign b        = tok.bytes[idx];

  always_comb begin
    pop = 1'b0;
    idx_next = idx;
    hold_valid_next = hold_valid;
    hold_byte_next  = hold_byte;
    hold_form_next  = hold_form;
    load_out = 1'b0;
    o = '0;
    if (have) begin
      if (at_byte) begin
        if (!final_b) begin
          if (!hold_valid || out_free) begin
            if (hold_valid) begin
              load_out = 1'b1;
              o = '{hold_byte, 1'b1, 1'b0, 1'b0, hold_form};
            end
            hold_valid_next = 1'b1;
            hold_byte_next  = b;
            hold_form_next  = tok.form;
            if (idx + 4'd1 == tok.nbytes) begin
              pop = 1'b1;
              idx_next = 4'd0;
            end else begin
              idx_next = idx + 4'd1;
            end
          end
        end else if (out_free) begin
          load_out = 1'b1;
          if (hold_valid) begin
            // release the older byte, keep this one for the closing step
            o = '{hold_byte, 1'b1, 1'b0, 1'b0, hold_form};
            hold_byte_next = b;
            hold_form_next = tok.form;
            idx_next = idx + 4'd1;
          end else begin
            o = '{b, 1'b1, 1'b1, tok.text_end, tok.form};
            pop = 1'b1;
            idx_next = 4'd0;
          end
        end
      end else if (!tok.item_last) begin
        pop = 1'b1;
        idx_next = 4'd0;
      end else if (out_free) begin
        if (hold_valid) begin
          load_out = 1'b1;
          o = '{hold_byte, 1'b1, 1'b1, tok.text_end, hold_form};
          hold_valid_next = 1'b0;
        end else if (tok.text_end) begin
          load_out = 1'b1;
          o = '{8'h00, 1'b0, 1'b1, 1'b1, tok.form};
        end
        pop = 1'b1;
        idx_next = 4'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= 4'd0;
      hold_valid <= 1'b0;
      dst_valid  <= 1'b0;
    end else begin
      idx        <= idx_next;
      hold_valid <= hold_valid_next;
      if (load_out) dst_valid <= 1'b1;
      else if (dst_ready) dst_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    hold_byte <= hold_byte_next;
    hold_form <= hold_form_next;
    if (load_out) dst_data <= o;
  end

endmodule

// File: src/tts_checker.sv
module tts_checker import tts_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      src_valid,
  input logic      src_ready,
  input in_item_t  src_data,
  input logic      dst_valid,
  input logic      dst_ready,
  input out_item_t dst_data
);

  a_dst_hold: assert property (@(posedge clk) disable iff (rst)
    dst_valid && !dst_ready |=> dst_valid && $stable(dst_data))
    else $error("dst result dropped or changed while stalled");

  a_bare_end: assert property (@(posedge clk) disable iff (rst)
    dst_valid && !dst_data.byte_valid |->
      dst_data.run_last && dst_data.output_end && dst_data.out_byte == 8'h00)
    else $error("bare result is not a text end");

  a_end_last: assert property (@(posedge clk) disable iff (rst)
    dst_valid && dst_data.output_end |-> dst_data.run_last)
    else $error("text end not on last result of a request");

  a_form: assert property (@(posedge clk) disable iff (rst)
    dst_valid |-> dst_data.detected_form <= FORM_BE32)
    else $error("detected form out of range");

  a_reset: assert property (@(posedge clk)
    rst |=> !dst_valid)
    else $error("result shown right after reset");

endmodule

bind text_to_utf8_sanitizer_core tts_checker u_chk (.*);
